// ===== rtl/core/wspm_pkg.sv =====
// Shared types, codes and fixed-point constants for the wheel speed PI / PWM mixer.
// Used by the sequencer, the shared multiplier and the top level. No dependencies.
`default_nettype none

package wspm_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_SPEED    = 3'd0,
        CFG_NORMAL_SPEED  = 3'd1,
        CFG_PROP_GAIN     = 3'd2,
        CFG_INT_GAIN      = 3'd3,
        CFG_LEFT_DEAD     = 3'd4,
        CFG_RIGHT_DEAD    = 3'd5,
        CFG_MAX_DUTY      = 3'd6,
        CFG_ENCODER_SCALE = 3'd7
    } t_cfg_idx;

    // Datapath widths: speeds Q16.8, accumulator Q24.16, integer wheel mix.
    localparam int SPEED_W = 24;
    localparam int ACC_W   = 40;
    localparam int MIX_W   = 25;

    // Shared multiplier: signed 33 x 25 with a registered product.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Fixed-point limits.
    localparam logic [27:0]        SPEED_CAP_Q8   = 28'd870400;     // 3400.0
    localparam logic [27:0]        REV_LIM_Q8     = 28'd8388608;    // 32768.0
    localparam logic signed [24:0] SLEW_Q8        = 25'sd76800;     // 300.0
    localparam logic signed [15:0] STRAIGHT_LIM   = 16'sd170;
    localparam logic signed [15:0] BLEND_LIM      = 16'sd400;
    localparam logic [20:0]        SLOW_TARGET_Q8 = 21'd71680;      // 280.0
    localparam logic signed [23:0] SEP_HI_Q8      = 24'sd76800;     // +300.0
    localparam logic signed [23:0] SEP_LO_Q8      = -24'sd76800;    // -300.0
    localparam logic signed [43:0] ACC_MAX_Q16    = 44'sd589824000; // 9000.0
    localparam logic signed [43:0] ACC_MIN        = -44'sd549755813888;
    localparam logic signed [15:0] SPD_OUT_MAX    = 16'sd4095;
    localparam logic signed [15:0] SPD_OUT_MIN    = -16'sd8192;

    // Sequencer states, one per step of the control tick.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_SPEED,
        ST_AVG,
        ST_SLEW,
        ST_DIFF,
        ST_MUL_P,
        ST_MUL_I,
        ST_ACC,
        ST_MIX,
        ST_DUTY
    } t_state;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_LEFT,
        MUL_RIGHT,
        MUL_PROP,
        MUL_INT
    } t_mul_sel;

    // Step strobes from the sequencer to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     left_spd;
        logic     right_spd;
        logic     avg;
        logic     slew;
        logic     diff;
        logic     acc_p;
        logic     acc_i;
        logic     mix;
        logic     out_load;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/wspm_mul.sv =====
// Shared signed multiplier with a registered product, reused for all four products.
// Depends on wspm_pkg for the operand widths.
`default_nettype none

module wspm_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [wspm_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [wspm_pkg::MUL_B_W-1:0] i_b,
    output logic signed [wspm_pkg::PROD_W-1:0]       o_prod
);
    import wspm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // One product per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/wspm_ctrl.sv =====
// Step sequencer of the control tick: walks the datapath through its steps.
// Depends on wspm_pkg for the state type and the strobe struct.
`default_nettype none

module wspm_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_out_space,
    output logic              o_busy,
    output wspm_pkg::t_ctrl   o_ctrl
);
    import wspm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a fixed walk, leaving only on a new item or a free output.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_SPEED;
            ST_SPEED: n_state = ST_AVG;
            ST_AVG:   n_state = ST_SLEW;
            ST_SLEW:  n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_MUL_I;
            ST_MUL_I: n_state = ST_ACC;
            ST_ACC:   n_state = ST_MIX;
            ST_MIX:   n_state = ST_DUTY;
            ST_DUTY:  if (i_out_space) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Step strobes for the datapath.
    always_comb begin
        o_ctrl         = '0;
        o_ctrl.mul_sel = MUL_LEFT;
        o_busy         = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy         = 1'b0;
                o_ctrl.load_in = i_in_valid;
            end
            ST_MUL_L: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_LEFT;
            end
            ST_MUL_R: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_sel  = MUL_RIGHT;
                o_ctrl.left_spd = 1'b1;
            end
            ST_SPEED: o_ctrl.right_spd = 1'b1;
            ST_AVG:   o_ctrl.avg = 1'b1;
            ST_SLEW:  o_ctrl.slew = 1'b1;
            ST_DIFF:  o_ctrl.diff = 1'b1;
            ST_MUL_P: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_PROP;
            end
            ST_MUL_I: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_INT;
                o_ctrl.acc_p   = 1'b1;
            end
            ST_ACC:  o_ctrl.acc_i = 1'b1;
            ST_MIX:  o_ctrl.mix = 1'b1;
            ST_DUTY: o_ctrl.out_load = i_out_space;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/wheel_speed_pi_pwm_mixer.sv =====
// Top level of the wheel speed PI controller and PWM mixer: registers, datapath, outputs.
// Depends on wspm_pkg, wspm_mul and wspm_ctrl.
`default_nettype none

// One control tick per item: both encoder counts become signed Q16.8 wheel speeds, their
// average is slew limited, a target is chosen from the track error and the mode flags, an
// incremental PI with integral separation updates the Q24.16 drive accumulator, and the
// result is mixed with the steering term into forward and reverse duties for each wheel.
// An item is accepted only while the sequencer is idle, so the block takes no new item
// before it has finished the last one, as the single 33 x 25 multiplier is used in turn
// for the two wheel speeds and the proportional and integral products, under a step
// sequencer. The result sits in an output register, so the next item is accepted while a
// finished result still waits; a stalled output holds the sequencer in its last step.
module wheel_speed_pi_pwm_mixer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration writes.
    input  wire logic                                i_cfg_we,
    input  wire logic [wspm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [wspm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [15:0]                         i_left_count,
    input  wire logic                                i_left_dir,
    input  wire logic [15:0]                         i_right_count,
    input  wire logic                                i_right_dir,
    input  wire logic signed [15:0]                  i_track_error,
    input  wire logic                                i_stop_request,
    input  wire logic                                i_slow_request,
    input  wire logic signed [15:0]                  i_steer_term,
    input  wire logic                                i_hold_mix,
    input  wire logic                                i_speed_enable,
    input  wire logic                                i_steer_enable,
    input  wire logic                                i_run_enable,
    // Output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [15:0]                              o_left_forward_duty,
    output logic [15:0]                              o_left_reverse_duty,
    output logic [15:0]                              o_right_forward_duty,
    output logic [15:0]                              o_right_reverse_duty,
    output logic signed [13:0]                       o_measured_speed,
    output logic signed [13:0]                       o_filtered_speed,
    output logic                                     o_fast_mode
);
    import wspm_pkg::*;

    // Turn a count-times-scale product into a signed Q16.8 wheel speed.
    function automatic logic signed [SPEED_W-1:0] f_wheel_speed(input logic [27:0] q8,
                                                                 input logic fwd);
        logic signed [SPEED_W-1:0] res;
        if (fwd) begin
            res = (q8 > SPEED_CAP_Q8) ? SPEED_CAP_Q8[SPEED_W-1:0] : q8[SPEED_W-1:0];
        end else if (q8 >= REV_LIM_Q8) begin
            res = REV_LIM_Q8[SPEED_W-1:0];
        end else begin
            res = -$signed({1'b0, q8[SPEED_W-2:0]});
        end
        return res;
    endfunction

    // Accumulator minus a signed offset, to integer, rounded toward zero. The offset is
    // one bit wider than the steering term so that its negation never overflows.
    function automatic logic signed [MIX_W-1:0] f_mix(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [16:0] steer);
        logic signed [ACC_W:0]    x;
        logic signed [MIX_W-1:0]  q;
        x = {acc[ACC_W-1], acc} - $signed({{8{steer[16]}}, steer, 16'd0});
        q = x[ACC_W:16];
        if (x[ACC_W] && (x[15:0] != 16'd0)) begin
            q = q + MIX_W'(1);
        end
        return q;
    endfunction

    // Dead-band offset plus mix magnitude, capped at the largest duty.
    function automatic logic [15:0] f_duty(input logic signed [MIX_W-1:0] mix,
                                           input logic [11:0] dead,
                                           input logic [15:0] dmax);
        logic [MIX_W-1:0] mag;
        logic [MIX_W:0]   d;
        mag = mix[MIX_W-1] ? MIX_W'(-mix) : MIX_W'(mix);
        d   = {{(MIX_W-11){1'b0}}, dead} + {1'b0, mag};
        return (d > {{(MIX_W-15){1'b0}}, dmax}) ? dmax : d[15:0];
    endfunction

    // Integer part of a Q16.8 speed, saturated to -8192 .. 4095 in the 14-bit output.
    function automatic logic signed [13:0] f_spd_out(input logic signed [SPEED_W-1:0] s);
        logic signed [15:0] q;
        q = s[SPEED_W-1:8];
        if (q > SPD_OUT_MAX) begin
            q = SPD_OUT_MAX;
        end else if (q < SPD_OUT_MIN) begin
            q = SPD_OUT_MIN;
        end
        return q[13:0];
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    t_ctrl ctrl;
    logic  busy;
    logic  out_space;

    logic [11:0] r_fast_speed, r_normal_speed, r_left_dead, r_right_dead;
    logic [31:0] r_prop_gain, r_int_gain;
    logic [15:0] r_max_duty, r_encoder_scale;

    logic [15:0]        r_lcnt, r_rcnt;
    logic               r_ldir, r_rdir, r_stop, r_slow, r_hold, r_spd_en, r_str_en, r_run;
    logic signed [15:0] r_te, r_steer;

    logic signed [SPEED_W-1:0] r_ls, r_rs, r_real, r_slew, r_err, r_prev_err;
    logic [20:0]               r_target;
    logic                      r_fast;
    logic signed [MUL_B_W-1:0] r_diff;
    logic signed [17:0]        r_errc;
    logic signed [42:0]        r_acc_sum;
    logic signed [ACC_W-1:0]   r_drive;
    logic signed [MIX_W-1:0]   r_lmix, r_rmix;

    logic               r_out_valid;
    logic [15:0]        r_lf, r_lr, r_rf, r_rr;
    logic signed [13:0] r_meas, r_filt;
    logic               r_fast_out;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [SPEED_W:0]   spd_sum;
    logic                      straight, blended;
    logic signed [SPEED_W:0]   slew_diff;
    logic signed [SPEED_W+1:0] err_raw;
    logic signed [SPEED_W-1:0] n_err;
    logic signed [SPEED_W-1:0] n_slew;
    logic signed [43:0]        acc_tot;
    logic signed [ACC_W-1:0]   n_drive;
    logic signed [15:0]        steer_eff;

    // ------------------------------------------------------------------
    // Sequencer and shared multiplier
    // ------------------------------------------------------------------
    assign out_space = !r_out_valid || !i_out_stall;

    wspm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_space (out_space),
        .o_busy      (busy),
        .o_ctrl      (ctrl)
    );

    assign o_in_stall = busy;

    // Operand selection for the multiplier.
    always_comb begin
        case (ctrl.mul_sel)
            MUL_LEFT: begin
                mul_a = $signed({17'd0, r_encoder_scale});
                mul_b = $signed({9'd0, r_lcnt});
            end
            MUL_RIGHT: begin
                mul_a = $signed({17'd0, r_encoder_scale});
                mul_b = $signed({9'd0, r_rcnt});
            end
            MUL_PROP: begin
                mul_a = $signed({1'b0, r_prop_gain});
                mul_b = r_diff;
            end
            MUL_INT: begin
                mul_a = $signed({1'b0, r_int_gain});
                mul_b = {{(MUL_B_W-18){r_errc[17]}}, r_errc};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    wspm_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_speed    <= 12'd1400;
            r_normal_speed  <= 12'd1000;
            r_prop_gain     <= 32'd107374182;
            r_int_gain      <= 32'd20133;
            r_left_dead     <= 12'd400;
            r_right_dead    <= 12'd430;
            r_max_duty      <= 16'd9000;
            r_encoder_scale <= 16'd8715;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FAST_SPEED:    r_fast_speed    <= i_cfg_data[11:0];
                CFG_NORMAL_SPEED:  r_normal_speed  <= i_cfg_data[11:0];
                CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                CFG_INT_GAIN:      r_int_gain      <= i_cfg_data;
                CFG_LEFT_DEAD:     r_left_dead     <= i_cfg_data[11:0];
                CFG_RIGHT_DEAD:    r_right_dead    <= i_cfg_data[11:0];
                CFG_MAX_DUTY:      r_max_duty      <= i_cfg_data[15:0];
                CFG_ENCODER_SCALE: r_encoder_scale <= i_cfg_data[15:0];
                default:           r_max_duty      <= r_max_duty;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input item capture
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (ctrl.load_in) begin
            r_lcnt   <= i_left_count;
            r_ldir   <= i_left_dir;
            r_rcnt   <= i_right_count;
            r_rdir   <= i_right_dir;
            r_te     <= i_track_error;
            r_stop   <= i_stop_request;
            r_slow   <= i_slow_request;
            r_steer  <= i_steer_term;
            r_hold   <= i_hold_mix;
            r_spd_en <= i_speed_enable;
            r_str_en <= i_steer_enable;
            r_run    <= i_run_enable;
        end
    end

    // ------------------------------------------------------------------
    // Step logic
    // ------------------------------------------------------------------

    // Average of the two wheel speeds, halved with floor.
    assign spd_sum = {r_ls[SPEED_W-1], r_ls} + {r_rs[SPEED_W-1], r_rs};

    // Target selection conditions.
    assign straight = (r_te <= STRAIGHT_LIM) && !r_stop && !r_slow;
    assign blended  = (r_te <= BLEND_LIM) && !r_stop && !r_slow;

    // Slew limit of the filtered speed, and the saturated speed error.
    assign slew_diff = {r_real[SPEED_W-1], r_real} - {r_slew[SPEED_W-1], r_slew};
    assign err_raw   = $signed({5'd0, r_target}) - {{2{r_real[SPEED_W-1]}}, r_real};

    always_comb begin
        if (slew_diff > SLEW_Q8) begin
            n_slew = SPEED_W'({r_slew[SPEED_W-1], r_slew} + SLEW_Q8);
        end else if (slew_diff < -SLEW_Q8) begin
            n_slew = SPEED_W'({r_slew[SPEED_W-1], r_slew} - SLEW_Q8);
        end else begin
            n_slew = r_real;
        end
        if (err_raw > 26'sd8388607) begin
            n_err = 24'sh7FFFFF;
        end else if (err_raw < -26'sd8388608) begin
            n_err = 24'sh800000;
        end else begin
            n_err = err_raw[SPEED_W-1:0];
        end
    end

    // Final accumulator sum with its limits and the speed enable.
    assign acc_tot = {r_acc_sum[42], r_acc_sum} + {{2{prod[PROD_W-1]}}, prod[PROD_W-1:16]};

    always_comb begin
        if (acc_tot >= ACC_MAX_Q16) begin
            n_drive = ACC_MAX_Q16[ACC_W-1:0];
        end else if (acc_tot < ACC_MIN) begin
            n_drive = ACC_MIN[ACC_W-1:0];
        end else begin
            n_drive = acc_tot[ACC_W-1:0];
        end
        if (!r_spd_en) begin
            n_drive = '0;
        end
    end

    assign steer_eff = r_str_en ? r_steer : 16'sd0;

    // Working registers without reset.
    always_ff @(posedge i_clk) begin
        if (ctrl.left_spd) begin
            r_ls <= f_wheel_speed(prod[31:4], r_ldir);
        end
        if (ctrl.right_spd) begin
            r_rs <= f_wheel_speed(prod[31:4], !r_rdir);
        end
        if (ctrl.avg) begin
            r_real <= spd_sum[SPEED_W:1];
            if (straight) begin
                r_target <= {1'b0, r_fast_speed, 8'd0};
            end else if (blended) begin
                r_target <= {1'b0, 13'({1'b0, r_fast_speed} + {1'b0, r_normal_speed}), 7'd0};
            end else if (r_slow) begin
                r_target <= SLOW_TARGET_Q8;
            end else begin
                r_target <= {1'b0, r_normal_speed, 8'd0};
            end
        end
        if (ctrl.slew) begin
            r_err <= n_err;
        end
        // The integral term uses the error only inside the separation band; the
        // band edges of +/-300.0 fit in the 18-bit clipped error.
        if (ctrl.diff) begin
            r_diff <= {r_err[SPEED_W-1], r_err} - {r_prev_err[SPEED_W-1], r_prev_err};
            r_errc <= ((r_err <= SEP_HI_Q8) && (r_err >= SEP_LO_Q8)) ? r_err[17:0] : 18'sd0;
        end
        // Accumulator plus the proportional term, floored to Q24.16.
        if (ctrl.acc_p) begin
            r_acc_sum <= {{3{r_drive[ACC_W-1]}}, r_drive}
                       + {prod[PROD_W-1], prod[PROD_W-1:16]};
        end
    end

    // Controller state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew     <= '0;
            r_fast     <= 1'b0;
            r_prev_err <= '0;
            r_drive    <= '0;
            r_lmix     <= '0;
            r_rmix     <= '0;
        end else begin
            if (ctrl.avg) begin
                if (straight) begin
                    r_fast <= 1'b1;
                end else if (!blended) begin
                    r_fast <= 1'b0;
                end
            end
            if (ctrl.slew) begin
                r_slew <= n_slew;
            end
            if (ctrl.diff) begin
                r_prev_err <= r_err;
            end
            if (ctrl.acc_i) begin
                r_drive <= n_drive;
            end
            if (ctrl.mix) begin
                if (!r_run) begin
                    r_lmix <= '0;
                    r_rmix <= '0;
                end else if (!r_hold) begin
                    r_lmix <= f_mix(r_drive, {steer_eff[15], steer_eff});
                    r_rmix <= f_mix(r_drive, -$signed({steer_eff[15], steer_eff}));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_lf       <= r_lmix[MIX_W-1] ? 16'd0 : f_duty(r_lmix, r_left_dead, r_max_duty);
            r_lr       <= r_lmix[MIX_W-1] ? f_duty(r_lmix, r_left_dead, r_max_duty) : 16'd0;
            r_rf       <= r_rmix[MIX_W-1] ? 16'd0 : f_duty(r_rmix, r_right_dead, r_max_duty);
            r_rr       <= r_rmix[MIX_W-1] ? f_duty(r_rmix, r_right_dead, r_max_duty) : 16'd0;
            r_meas     <= f_spd_out(r_real);
            r_filt     <= f_spd_out(r_slew);
            r_fast_out <= r_fast;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_left_forward_duty  = r_lf;
    assign o_left_reverse_duty  = r_lr;
    assign o_right_forward_duty = r_rf;
    assign o_right_reverse_duty = r_rr;
    assign o_measured_speed     = r_meas;
    assign o_filtered_speed     = r_filt;
    assign o_fast_mode          = r_fast_out;

endmodule

`default_nettype wire

// ===== rtl/core/wspm_chk.sv =====
// Port-level checker for the wheel speed PI / PWM mixer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module wspm_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_left_forward_duty,
    input wire logic [15:0] o_left_reverse_duty,
    input wire logic [15:0] o_right_forward_duty,
    input wire logic [15:0] o_right_reverse_duty
);

    // A stalled result item keeps its valid and its left forward, right forward and left reverse duties.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_left_forward_duty)
            && $stable(o_right_forward_duty) && $stable(o_left_reverse_duty)))
        else $error("stalled result item changed");

    // A wheel never drives forward and reverse at once.
    a_dir_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_left_forward_duty == 16'd0 || o_left_reverse_duty == 16'd0)
            && (o_right_forward_duty == 16'd0 || o_right_reverse_duty == 16'd0)))
        else $error("forward and reverse duty both set");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took two items back to back");

    // A new result only appears at the end of a busy tick.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item appeared without work");

endmodule

bind wheel_speed_pi_pwm_mixer wspm_chk u_wspm_chk (.*);

`default_nettype wire
